>>> hw/rtl/asoc_pkg.sv
// Package with the widths and constants of the accelerometer offset calibrator.
package asoc_pkg;

   localparam int CAL_LOG2   = 11;
   localparam int WORD_W     = 16;
   localparam int SAMPLE_SH  = 6;
   localparam int SAMPLE_W   = WORD_W - SAMPLE_SH;
   localparam int SCALED_W   = SAMPLE_W + 3;
   localparam int CSAMPLE_W  = 13;
   localparam int SUM_W      = CSAMPLE_W + CAL_LOG2;
   localparam int OFS_W      = 12;
   localparam int VALUE_W    = 14;
   localparam int SCALE_W    = 2;
   localparam int GRAV_W     = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int AXES       = 3;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic [SCALE_W-1:0] SCALE_RESET   = 2'd1;
   localparam logic [GRAV_W-1:0]  GRAVITY_RESET = 11'd1000;

   localparam logic signed [CSAMPLE_W-1:0] OFS_MAX = 13'sd2047;
   localparam logic signed [CSAMPLE_W-1:0] OFS_MIN = -13'sd2048;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SCALE_CODE  = 2'd0,
      REG_CALIBRATING = 2'd1,
      REG_GRAVITY_MG  = 2'd2
   } reg_index_type;

endpackage

>>> hw/rtl/accel_sample_offset_calibrator_unit.sv
// Top level of the accelerometer offset calibrator.
//
// Each request transfer carries three raw 16-bit accelerometer words. Every
// word is reduced to a 10-bit sample by an arithmetic right shift of six.
// With calibrating clear, each sample is shifted left by scale_code, the
// stored offset of its axis is subtracted, and one response transfer with
// tuser low carries the three corrected values in mg.
// With calibrating set, the samples are summed per axis with gravity_mg
// taken from Z, and no response is sent until the 2^CAL_LOG2-th sample. That
// sample produces one response with tuser high that carries the new offsets,
// which are also stored; the sums and the sample counter then restart.
// Registers are written through the csr channel, which is always ready;
// writes belong only to idle periods, and an index past the list is ignored.
// An item passes an input register and then a result register before
// rsp_tvalid rises. One item is taken every cycle while rsp_tready
// is high; the result register can hold a finished response while the input
// register takes the next request. When the receiver stalls, items back up
// into those two registers and then req_tready falls.
// Reset restores scale_code 1, calibrating 0, gravity_mg 1000, and clears
// the offsets, the sums, the counter and both registers' valid flags.
module accel_sample_offset_calibrator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // x_word [15:0], y_word [31:16], z_word [47:32].
   input  logic [asoc_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // x_value [13:0], y_value [27:14], z_value [41:28], zero fill above.
   output logic [asoc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // is_offset [0].
   output logic                                  rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [asoc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [asoc_pkg::GRAV_W-1:0]           csr_data
);

   logic [asoc_pkg::SCALE_W-1:0] scale_ff;
   logic                         cal_ff;
   logic [asoc_pkg::GRAV_W-1:0]  grav_ff;

   logic                                s1_valid_ff;
   logic [asoc_pkg::WORD_W-1:0]         s1_word_ff [asoc_pkg::AXES];

   logic signed [asoc_pkg::OFS_W-1:0]   ofs_ff  [asoc_pkg::AXES];
   logic signed [asoc_pkg::OFS_W-1:0]   ofs_in  [asoc_pkg::AXES];
   logic signed [asoc_pkg::SUM_W-1:0]   sum_ff  [asoc_pkg::AXES];
   logic signed [asoc_pkg::SUM_W-1:0]   sum_in  [asoc_pkg::AXES];
   logic [asoc_pkg::CAL_LOG2-1:0]       count_ff;
   logic [asoc_pkg::CAL_LOG2-1:0]       count_in;

   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic signed [asoc_pkg::VALUE_W-1:0] out_value_ff [asoc_pkg::AXES];
   logic signed [asoc_pkg::VALUE_W-1:0] out_value_in [asoc_pkg::AXES];
   logic                                out_flag_ff;
   logic                                out_flag_in;

   logic                                  s1_fire;
   logic                                  cal_done;
   logic signed [asoc_pkg::SAMPLE_W-1:0]  sample    [asoc_pkg::AXES];
   logic signed [asoc_pkg::CSAMPLE_W-1:0] csample   [asoc_pkg::AXES];
   logic signed [asoc_pkg::SUM_W-1:0]     sum_next  [asoc_pkg::AXES];
   logic signed [asoc_pkg::CSAMPLE_W-1:0] avg       [asoc_pkg::AXES];
   logic signed [asoc_pkg::OFS_W-1:0]     avg_sat   [asoc_pkg::AXES];
   logic signed [asoc_pkg::SCALED_W-1:0]  scaled    [asoc_pkg::AXES];
   logic signed [asoc_pkg::VALUE_W-1:0]   corrected [asoc_pkg::AXES];

   assign csr_ready  = 1'b1;
   assign s1_fire    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign cal_done   = (count_ff == {asoc_pkg::CAL_LOG2{1'b1}});

   always_comb begin
      for (int i = 0; i < asoc_pkg::AXES; i++) begin
         sample[i]  = signed'(s1_word_ff[i][asoc_pkg::WORD_W-1:asoc_pkg::SAMPLE_SH]);
         csample[i] = {{(asoc_pkg::CSAMPLE_W-asoc_pkg::SAMPLE_W){sample[i][asoc_pkg::SAMPLE_W-1]}},
                       sample[i]};
         if (i == asoc_pkg::AXES - 1) begin
            csample[i] = csample[i]
                       - signed'({{(asoc_pkg::CSAMPLE_W-asoc_pkg::GRAV_W){1'b0}}, grav_ff});
         end
         sum_next[i] = sum_ff[i]
                     + {{(asoc_pkg::SUM_W-asoc_pkg::CSAMPLE_W){csample[i][asoc_pkg::CSAMPLE_W-1]}},
                        csample[i]};
         avg[i] = sum_next[i][asoc_pkg::SUM_W-1:asoc_pkg::CAL_LOG2];
         if (avg[i] > asoc_pkg::OFS_MAX) begin
            avg_sat[i] = asoc_pkg::OFS_MAX[asoc_pkg::OFS_W-1:0];
         end else if (avg[i] < asoc_pkg::OFS_MIN) begin
            avg_sat[i] = asoc_pkg::OFS_MIN[asoc_pkg::OFS_W-1:0];
         end else begin
            avg_sat[i] = avg[i][asoc_pkg::OFS_W-1:0];
         end
         scaled[i] = {{(asoc_pkg::SCALED_W-asoc_pkg::SAMPLE_W){sample[i][asoc_pkg::SAMPLE_W-1]}},
                      sample[i]} <<< scale_ff;
         corrected[i] = {{(asoc_pkg::VALUE_W-asoc_pkg::SCALED_W){scaled[i][asoc_pkg::SCALED_W-1]}},
                         scaled[i]}
                      - {{(asoc_pkg::VALUE_W-asoc_pkg::OFS_W){ofs_ff[i][asoc_pkg::OFS_W-1]}},
                         ofs_ff[i]};
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_flag_in  = out_flag_ff;
      count_in     = count_ff;
      for (int i = 0; i < asoc_pkg::AXES; i++) begin
         out_value_in[i] = out_value_ff[i];
         ofs_in[i]       = ofs_ff[i];
         sum_in[i]       = sum_ff[i];
      end
      if (s1_fire) begin
         if (!cal_ff) begin
            out_valid_in = 1'b1;
            out_flag_in  = 1'b0;
            for (int i = 0; i < asoc_pkg::AXES; i++) begin
               out_value_in[i] = corrected[i];
            end
         end else begin
            count_in     = count_ff + 1'b1;
            out_valid_in = cal_done;
            out_flag_in  = 1'b1;
            for (int i = 0; i < asoc_pkg::AXES; i++) begin
               if (cal_done) begin
                  sum_in[i]       = '0;
                  ofs_in[i]       = avg_sat[i];
                  out_value_in[i] = {{(asoc_pkg::VALUE_W-asoc_pkg::OFS_W){avg_sat[i][asoc_pkg::OFS_W-1]}},
                                     avg_sat[i]};
               end else begin
                  sum_in[i] = sum_next[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= asoc_pkg::SCALE_RESET;
         cal_ff       <= 1'b0;
         grav_ff      <= asoc_pkg::GRAVITY_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int i = 0; i < asoc_pkg::AXES; i++) begin
            ofs_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               asoc_pkg::REG_SCALE_CODE:  scale_ff <= csr_data[asoc_pkg::SCALE_W-1:0];
               asoc_pkg::REG_CALIBRATING: cal_ff   <= csr_data[0];
               asoc_pkg::REG_GRAVITY_MG:  grav_ff  <= csr_data;
               default: ;
            endcase
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         for (int i = 0; i < asoc_pkg::AXES; i++) begin
            ofs_ff[i] <= ofs_in[i];
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         for (int i = 0; i < asoc_pkg::AXES; i++) begin
            s1_word_ff[i] <= req_tdata[i*asoc_pkg::WORD_W +: asoc_pkg::WORD_W];
         end
      end
      out_flag_ff <= out_flag_in;
      for (int i = 0; i < asoc_pkg::AXES; i++) begin
         out_value_ff[i] <= out_value_in[i];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_flag_ff;
   assign rsp_tdata  = {{(asoc_pkg::RSP_DATA_W-asoc_pkg::AXES*asoc_pkg::VALUE_W){1'b0}},
                        out_value_ff[2], out_value_ff[1], out_value_ff[0]};

endmodule

>>> tb/sv/accel_sample_offset_calibrator_unit_test.sv
// Self-checking testbench for the accelerometer offset calibrator.
module accel_sample_offset_calibrator_unit_test;

   localparam int SETTLE_CYCLES = 4;
   localparam int QUIET_LIMIT   = 2000;
   localparam logic [asoc_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [asoc_pkg::WORD_W-1:0] z_word;
      logic [asoc_pkg::WORD_W-1:0] y_word;
      logic [asoc_pkg::WORD_W-1:0] x_word;
   } accel_words_type;

   typedef struct packed {
      logic                         is_offset;
      logic [asoc_pkg::VALUE_W-1:0] z_value;
      logic [asoc_pkg::VALUE_W-1:0] y_value;
      logic [asoc_pkg::VALUE_W-1:0] x_value;
   } mg_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // x_word [15:0], y_word [31:16], z_word [47:32].
   logic [asoc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // x_value [13:0], y_value [27:14], z_value [41:28], zero fill above.
   logic [asoc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   // is_offset [0].
   logic                            rsp_tuser;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [asoc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [asoc_pkg::GRAV_W-1:0]     csr_data = '0;

   logic [asoc_pkg::SCALE_W-1:0]      cfg_scale = asoc_pkg::SCALE_RESET;
   logic                              cfg_calibrating = 1'b0;
   logic [asoc_pkg::GRAV_W-1:0]       cfg_gravity = asoc_pkg::GRAVITY_RESET;
   logic signed [asoc_pkg::OFS_W-1:0] axis_offset [asoc_pkg::AXES] = '{default: '0};
   logic signed [asoc_pkg::SUM_W-1:0] axis_sum [asoc_pkg::AXES] = '{default: '0};
   int                                cal_count = 0;

   mg_result_type expected_mg [$];
   int gap_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int samples_sent = 0;
   int reg_writes = 0;
   int offset_updates = 0;
   int samples_checked = 0;
   int offsets_checked = 0;
   int quiet_cycles = 0;

   accel_sample_offset_calibrator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic void predict_mg(input accel_words_type w);
      int smp [asoc_pkg::AXES];
      int vals [asoc_pkg::AXES];
      int ofs;
      mg_result_type res;
      smp[0] = int'($signed(w.x_word[asoc_pkg::WORD_W-1:asoc_pkg::SAMPLE_SH]));
      smp[1] = int'($signed(w.y_word[asoc_pkg::WORD_W-1:asoc_pkg::SAMPLE_SH]));
      smp[2] = int'($signed(w.z_word[asoc_pkg::WORD_W-1:asoc_pkg::SAMPLE_SH]));
      res = '0;
      if (!cfg_calibrating) begin
         for (int i = 0; i < asoc_pkg::AXES; i++) begin
            vals[i] = (smp[i] <<< cfg_scale) - int'(axis_offset[i]);
         end
      end else begin
         smp[2] = smp[2] - int'(cfg_gravity);
         for (int i = 0; i < asoc_pkg::AXES; i++) begin
            axis_sum[i] = asoc_pkg::SUM_W'(int'(axis_sum[i]) + smp[i]);
         end
         cal_count++;
         if (cal_count < (1 << asoc_pkg::CAL_LOG2)) begin
            return;
         end
         for (int i = 0; i < asoc_pkg::AXES; i++) begin
            ofs = int'(axis_sum[i]) >>> asoc_pkg::CAL_LOG2;
            if (ofs > int'(asoc_pkg::OFS_MAX)) begin
               ofs = int'(asoc_pkg::OFS_MAX);
            end
            if (ofs < int'(asoc_pkg::OFS_MIN)) begin
               ofs = int'(asoc_pkg::OFS_MIN);
            end
            axis_offset[i] = ofs[asoc_pkg::OFS_W-1:0];
            axis_sum[i] = '0;
            vals[i] = ofs;
         end
         cal_count = 0;
         res.is_offset = 1'b1;
         offset_updates++;
      end
      res.x_value = vals[0][asoc_pkg::VALUE_W-1:0];
      res.y_value = vals[1][asoc_pkg::VALUE_W-1:0];
      res.z_value = vals[2][asoc_pkg::VALUE_W-1:0];
      expected_mg.push_back(res);
   endfunction

   function automatic logic [asoc_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return asoc_pkg::WORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [asoc_pkg::WORD_W-1:0] near_word(input int center, input int spread);
      int v;
      v = center + int'($urandom_range(2 * spread)) - spread;
      if (v > 32767) begin
         v = 32767;
      end
      if (v < -32768) begin
         v = -32768;
      end
      return v[asoc_pkg::WORD_W-1:0];
   endfunction

   function automatic accel_words_type random_words();
      accel_words_type w;
      w.x_word = pick_word();
      w.y_word = pick_word();
      w.z_word = pick_word();
      return w;
   endfunction

   task automatic send_words(input accel_words_type w);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      predict_mg(w);
      samples_sent++;
   endtask

   task automatic write_reg(input logic [asoc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [asoc_pkg::GRAV_W-1:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_mg.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      unique case (idx)
         asoc_pkg::REG_SCALE_CODE:  cfg_scale = value[asoc_pkg::SCALE_W-1:0];
         asoc_pkg::REG_CALIBRATING: cfg_calibrating = value[0];
         asoc_pkg::REG_GRAVITY_MG:  cfg_gravity = value;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_corner_set();
      send_words('{x_word: 16'h8000, y_word: 16'h7FFF, z_word: 16'hFFC0});
      send_words('{x_word: 16'h7FFF, y_word: 16'h8000, z_word: 16'h0040});
      send_words('{x_word: 16'h0000, y_word: 16'hFFFF, z_word: 16'h003F});
   endtask

   task automatic calibrate_axes(input int breaks_per_mille, input int z_center,
                                 input int z_spread);
      int center [asoc_pkg::AXES];
      int done;
      int n;
      accel_words_type w;
      for (int i = 0; i < asoc_pkg::AXES - 1; i++) begin
         center[i] = int'($urandom_range(64000)) - 32000;
      end
      center[2] = z_center;
      done = offset_updates;
      n = 0;
      write_reg(asoc_pkg::REG_CALIBRATING, 11'd1);
      while (offset_updates == done) begin
         if (n == 700 || $urandom_range(999) < breaks_per_mille) begin
            write_reg(asoc_pkg::REG_CALIBRATING, 11'h7FE);
            if ($urandom_range(1)) begin
               write_reg(asoc_pkg::REG_SCALE_CODE, asoc_pkg::GRAV_W'($urandom));
            end
            repeat ($urandom_range(1, 8)) send_words(random_words());
            write_reg(asoc_pkg::REG_CALIBRATING, 11'd1);
         end
         w.x_word = near_word(center[0], 3000);
         w.y_word = near_word(center[1], 3000);
         w.z_word = near_word(center[2], z_spread);
         send_words(w);
         n++;
      end
      write_reg(asoc_pkg::REG_CALIBRATING, 11'd0);
   endtask

   task automatic test_reset_and_bad_index();
      send_corner_set();
      write_reg(REG_UNUSED, 11'h7FF);
      send_corner_set();
   endtask

   task automatic test_scale_extremes();
      for (int sc = 0; sc < 4; sc++) begin
         write_reg(asoc_pkg::REG_SCALE_CODE, asoc_pkg::GRAV_W'(sc));
         send_corner_set();
      end
   endtask

   task automatic test_offset_saturation();
      write_reg(asoc_pkg::REG_GRAVITY_MG, 11'h7FF);
      calibrate_axes(3, -32768, 0);
      write_reg(asoc_pkg::REG_SCALE_CODE, 11'd3);
      send_corner_set();
      write_reg(asoc_pkg::REG_SCALE_CODE, 11'd0);
      send_corner_set();
   endtask

   task automatic test_random_samples(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         write_reg(asoc_pkg::REG_SCALE_CODE, asoc_pkg::GRAV_W'($urandom));
         if ($urandom_range(3) == 0) begin
            write_reg(asoc_pkg::REG_GRAVITY_MG, asoc_pkg::GRAV_W'($urandom));
         end
         repeat ($urandom_range(5, 60)) begin
            send_words(random_words());
            sent++;
         end
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      mg_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_mg.size() == 0) begin
            $error("response transfer with no expected result");
            mismatch_count++;
         end else begin
            want = expected_mg.pop_front();
            check_field("x_value", int'($signed(want.x_value)),
                        int'($signed(rsp_tdata[asoc_pkg::VALUE_W-1:0])));
            check_field("y_value", int'($signed(want.y_value)),
                        int'($signed(rsp_tdata[2*asoc_pkg::VALUE_W-1:asoc_pkg::VALUE_W])));
            check_field("z_value", int'($signed(want.z_value)),
                        int'($signed(rsp_tdata[3*asoc_pkg::VALUE_W-1:2*asoc_pkg::VALUE_W])));
            check_field("is_offset", int'(want.is_offset), int'(rsp_tuser));
            check_field("tdata fill", 0,
                        int'(rsp_tdata[asoc_pkg::RSP_DATA_W-1:3*asoc_pkg::VALUE_W]));
            if (want.is_offset) begin
               offsets_checked++;
            end else begin
               samples_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_pct = 37;
      stall_pct = 46;
      test_reset_and_bad_index();
      test_scale_extremes();
      test_offset_saturation();
      test_random_samples(100);

      gap_pct = 46;
      stall_pct = 37;
      test_scale_extremes();
      test_random_samples(100);

      gap_pct = 0;
      stall_pct = 0;
      test_scale_extremes();
      test_random_samples(100);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_mg.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d sensor samples and %0d register writes under three pacing profiles.",
               samples_sent, reg_writes);
      $display("Checked %0d corrected samples and %0d offset updates, incl. saturation.",
               samples_checked, offsets_checked);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
